/* hdl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SCPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SCPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/scpd_pkg.sv */
package scpd_pkg;

   localparam int SIZE_BYTES_DEFAULT = 2;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd255;
   localparam logic [7:0]  START_BYTE       = 8'h24;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM  = 2'd2;
   localparam logic [1:0] KIND_OVERLONG = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } rx_item_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] frame_length;
      logic        last;
   } rsp_item_type;

endpackage

/* hdl/scpd_in_stage.sv */
module scpd_in_stage
   import scpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        advance,
   output rx_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

/* hdl/scpd_parser.sv */
module scpd_parser
   import scpd_pkg::*;
#(
   parameter int SIZE_BYTES = SIZE_BYTES_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data,
   input  rx_item_type  item,
   input  logic         advance,
   output rsp_item_type result
);

   localparam int CNT_W = (SIZE_BYTES > 1) ? $clog2(SIZE_BYTES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SIZE_BYTES - 1);

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_SUM  = 2'd3;

   logic [15:0]      max_length_ff;
   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      rem_ff, rem_in;
   logic [7:0]       sum_ff, sum_in;
   logic             ovf_ff, ovf_in;
   logic             fire;
   logic [7:0]       b;

   assign fire = item.valid && advance;
   assign b    = item.rx_byte;

   always_comb begin
      phase_in            = phase_ff;
      cnt_in              = cnt_ff;
      len_in              = len_ff;
      rem_in              = rem_ff;
      sum_in              = sum_ff;
      ovf_in              = ovf_ff;
      result.valid        = 1'b0;
      result.kind         = KIND_PAYLOAD;
      result.data         = 8'h00;
      result.last         = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (b == START_BYTE) begin
                  phase_in = PH_LEN;
                  cnt_in   = '0;
                  len_in   = '0;
                  ovf_in   = 1'b0;
               end
            end
            PH_LEN: begin
               if (cnt_ff == '0) begin
                  len_in = {8'h00, b};
               end else if (cnt_ff == CNT_W'(1)) begin
                  len_in = {b, len_ff[7:0]};
               end else if (b != 8'h00) begin
                  ovf_in = 1'b1;
               end
               if (cnt_ff == CNT_LAST) begin
                  if (ovf_in || len_in > max_length_ff) begin
                     if (ovf_in) begin
                        len_in = 16'hFFFF;
                     end
                     phase_in     = PH_HUNT;
                     result.valid = 1'b1;
                     result.kind  = KIND_OVERLONG;
                     result.last  = 1'b1;
                  end else begin
                     sum_in   = 8'h00;
                     rem_in   = len_in;
                     phase_in = (len_in == 16'h0000) ? PH_SUM : PH_DATA;
                  end
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            PH_DATA: begin
               sum_in = sum_ff + b;
               rem_in = rem_ff - 16'd1;
               if (rem_in == 16'h0000) begin
                  phase_in = PH_SUM;
               end
               result.valid = 1'b1;
               result.data  = b;
            end
            PH_SUM: begin
               phase_in     = PH_HUNT;
               result.valid = 1'b1;
               result.kind  = (b == sum_ff) ? KIND_GOOD : KIND_BAD_SUM;
               result.last  = 1'b1;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
      result.frame_length = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         phase_ff      <= PH_HUNT;
         cnt_ff        <= '0;
         len_ff        <= '0;
         rem_ff        <= '0;
         sum_ff        <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

/* hdl/scpd_out_stage.sv */
module scpd_out_stage
   import scpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_item_type result,
   output logic         advance,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_kind,
   output logic [7:0]   rsp_data,
   output logic [15:0]  rsp_frame_length,
   output logic         rsp_last
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [7:0]  data_ff;
   logic [15:0] length_ff;
   logic        last_ff;

   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         kind_ff   <= result.kind;
         data_ff   <= result.data;
         length_ff <= result.frame_length;
         last_ff   <= result.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_data         = data_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_last         = last_ff;

endmodule

/* hdl/sum_checked_packet_deframer_top.sv */
// Length-prefixed frame receiver with an 8-bit additive checksum.
// req channel: one received serial byte per word (req_rx_byte). The block
//   hunts for '$', gathers a little-endian length of SIZE_BYTES bytes, then
//   passes the payload and checks one trailing sum byte.
// rsp channel: one word per payload byte (kind 0), and one closing word per
//   frame: good (1), checksum mismatch (2) or length over max_length (3).
//   Bytes that open no result (hunt, length) produce no rsp word.
// csr port: csr_write_enable/csr_write_data write max_length; write it only
//   while the block is idle.
// Path: an accepted byte waits in the input register; its parse is
//   combinational and the result is registered in the result register,
//   which drives rsp. Throughput is one byte per cycle while rsp_stall does
//   not hold it, set by the single parse stage between the two registers.
// Stall: while rsp_stall holds a waiting result, the parse stage stops and
//   req_stall rises once the input register is also full; nothing is lost.
// Reset (synchronous, active high): clears both registers' valid flags,
//   returns to hunting and sets max_length to 255.
module sum_checked_packet_deframer_top
   import scpd_pkg::*;
#(
   parameter int SIZE_BYTES = SIZE_BYTES_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   rx_item_type  item;
   rsp_item_type result;
   logic         advance;

   scpd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item        (item)
   );

   scpd_parser #(
      .SIZE_BYTES (SIZE_BYTES)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item             (item),
      .advance          (advance),
      .result           (result)
   );

   scpd_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last)
   );

endmodule

/* hdl/scpd_checker.sv */
`include "assert_macros.svh"

module scpd_checker
   import scpd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data,
   input logic [15:0] rsp_frame_length,
   input logic        rsp_last,
   input logic        csr_write_enable,
   input logic [15:0] csr_write_data
);

   `SCPD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data) && $stable(rsp_frame_length) && $stable(rsp_last), "stalled rsp word changed")
   `SCPD_ASSERT(a_last_kind, clock, reset, rsp_valid |-> (rsp_last == (rsp_kind != KIND_PAYLOAD)), "rsp_last disagrees with rsp_kind")
   `SCPD_ASSERT(a_data_zero, clock, reset, rsp_valid && rsp_kind != KIND_PAYLOAD |-> rsp_data == 8'h00, "closing word carries data")
   `SCPD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp word right after reset")

endmodule

bind sum_checked_packet_deframer_top scpd_checker u_scpd_checker (.*);
